// ===== rtl/core/gcdp_pkg.sv =====
// Package for the great-circle destination point pipeline.
// Holds Q30 angle constants, the CORDIC arctangent table and the small helper functions.
// No dependencies.
package gcdp_pkg;

  localparam int AW = 34;          // Q30 angle / sine-cosine width, signed
  localparam int VW = 36;          // vectoring CORDIC x/y width, signed
  localparam int DIV_BITS = 62;    // quotient bits of (distance << 30) / radius
  localparam int SQRT_STEPS = 31;  // result bits of the square root of a 61-bit value

  localparam logic [31:0] RADIUS_RESET = 32'd6371000;

  localparam logic signed [AW-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic [AW-1:0]        TWO_PI_U    = 34'd6746518852;
  localparam logic signed [AW-1:0] GAIN_Q30    = 34'sd652032874;

  // pi/180 * 2^40, split in two so each partial product stays narrow
  localparam logic [34:0]        DEG2RAD_C = 35'd19190098069;
  localparam logic signed [18:0] D2R_LO    = {1'b0, DEG2RAD_C[17:0]};
  localparam logic signed [17:0] D2R_HI    = {1'b0, DEG2RAD_C[34:18]};

  // 180/pi * 2^24
  localparam logic signed [30:0] RAD2DEG_S = 31'sd961263669;

  typedef struct packed {
    logic signed [AW-1:0] z;
    logic                 neg;
  } fold_t;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic signed [AW-1:0] a;
    case (i)
      0:  a = 34'sh3243F6A8;
      1:  a = 34'sh1DAC6705;
      2:  a = 34'sh0FADBAFC;
      3:  a = 34'sh07F56EA6;
      4:  a = 34'sh03FEAB76;
      5:  a = 34'sh01FFD55B;
      6:  a = 34'sh00FFFAAA;
      7:  a = 34'sh007FFF55;
      8:  a = 34'sh003FFFEA;
      9:  a = 34'sh001FFFFD;
      10: a = 34'sh000FFFFF;
      11: a = 34'sh0007FFFF;
      12: a = 34'sh0003FFFF;
      13: a = 34'sh0001FFFF;
      14: a = 34'sh0000FFFF;
      15: a = 34'sh00007FFF;
      16: a = 34'sh00003FFF;
      17: a = 34'sh00001FFF;
      18: a = 34'sh00000FFF;
      19: a = 34'sh000007FF;
      20: a = 34'sh000003FF;
      21: a = 34'sh000001FF;
      22: a = 34'sh000000FF;
      23: a = 34'sh0000007F;
      24: a = 34'sh0000003F;
      25: a = 34'sh0000001F;
      26: a = 34'sh0000000F;
      27: a = 34'sh00000008;
      28: a = 34'sh00000004;
      29: a = 34'sh00000002;
      30: a = 34'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // One radix-2 step of a residue mod 2*pi: m' = (2m + b) mod 2*pi
  function automatic logic [32:0] mod_step(input logic [32:0] m, input logic b);
    logic [AW-1:0] t;
    t = {m, b};
    if (t >= TWO_PI_U) t = t - TWO_PI_U;
    return t[32:0];
  endfunction

  // Residue to (-pi, pi], then fold into [-pi/2, pi/2] with a sign flag
  function automatic fold_t wrap_fold(input logic [32:0] m, input logic neg_in);
    fold_t f;
    logic signed [AW-1:0] z;
    z = signed'({1'b0, m});
    if (neg_in && (m != '0)) z = TWO_PI_Q30 - z;
    if (z > PI_Q30) z = z - TWO_PI_Q30;
    f.neg = 1'b0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      f.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      f.neg = 1'b1;
    end
    f.z = z;
    return f;
  endfunction

  // Q30 product, floored
  function automatic logic signed [AW-1:0] qmul(input logic signed [AW-1:0] a,
                                                input logic signed [AW-1:0] b);
    logic signed [2*AW-1:0] p;
    p = a * b;
    return p[AW+29:30];
  endfunction

endpackage

// ===== rtl/core/great_circle_destination_point.sv =====
// Top level of the great-circle destination point pipeline.
// Depends on gcdp_pkg for constants, the arctangent table and helper functions.
//
// Channel  Handshake             Payload
// in       in_valid / in_stall   start_lat, start_lon, azimuth, travel_distance
// out      out_valid / out_stall dest_lat, dest_lon
// cfg      cfg_wr_en             cfg_wr_data (sphere radius)
//
// One item per cycle while the output is not stalled. The pipeline is made up of the
// 62 one-bit divider steps, the 31 square-root steps and
// the two CORDIC chains (rotation, then vectoring).
// Reset is synchronous: it clears all valid bits and loads the radius with 6371000.
// A stall on a valid output freezes every stage; in_stall rises in the same cycle.
module great_circle_destination_point
  import gcdp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_start_lat,
  input  logic signed [24:0] in_start_lon,
  input  logic signed [25:0] in_azimuth,
  input  logic [31:0]        in_travel_distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_dest_lat,
  output logic signed [25:0] out_dest_lon,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  localparam int CS = CORDIC_STAGES;
  localparam int DW = 53 - ANGLE_FRAC_BITS;  // radians after degree conversion
  localparam int DSH = ANGLE_FRAC_BITS + 10;
  localparam int RSH = 54 - ANGLE_FRAC_BITS;
  localparam int MW = AW + 31;               // radians times degree constant
  localparam logic signed [AW-1:0] Z_ORIGIN = '0;

  logic        adv;
  logic [31:0] radius_r;
  logic [31:0] divisor;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  assign divisor = (radius_r == '0) ? 32'd1 : radius_r;

  // whole pipeline moves together; hold everything while a result waits
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- S0: input capture ----------------
  logic               s0_vld_r;
  logic signed [23:0] s0_lat_r;
  logic signed [24:0] s0_lon_r;
  logic signed [25:0] s0_az_r;
  logic [31:0]        s0_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r  <= in_valid;
      s0_lat_r  <= in_start_lat;
      s0_lon_r  <= in_start_lon;
      s0_az_r   <= in_azimuth;
      s0_dist_r <= in_travel_distance;
    end
  end

  // ---------------- S1: degree-to-radian partial products ----------------
  logic               s1_vld_r;
  logic signed [42:0] s1_latlo_r;
  logic signed [41:0] s1_lathi_r;
  logic signed [44:0] s1_azlo_r;
  logic signed [43:0] s1_azhi_r;
  logic signed [24:0] s1_lon_r;
  logic [31:0]        s1_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r   <= s0_vld_r;
      s1_latlo_r <= s0_lat_r * D2R_LO;
      s1_lathi_r <= s0_lat_r * D2R_HI;
      s1_azlo_r  <= s0_az_r * D2R_LO;
      s1_azhi_r  <= s0_az_r * D2R_HI;
      s1_lon_r   <= s0_lon_r;
      s1_dist_r  <= s0_dist_r;
    end
  end

  // ---------------- S2: round, split sign and magnitude ----------------
  logic signed [63:0] lat_sum, az_sum, lat_rnd, az_rnd;
  logic [DW-1:0]      lat_rad, az_rad, lat_mag, az_mag;

  always_comb begin
    lat_sum = (64'(s1_lathi_r) <<< 18) + 64'(s1_latlo_r);
    az_sum  = (64'(s1_azhi_r) <<< 18) + 64'(s1_azlo_r);
    lat_rnd = (lat_sum + (64'sd1 <<< (DSH - 1))) >>> DSH;
    az_rnd  = (az_sum + (64'sd1 <<< (DSH - 1))) >>> DSH;
    lat_rad = lat_rnd[DW-1:0];
    az_rad  = az_rnd[DW-1:0];
    lat_mag = lat_rad[DW-1] ? (~lat_rad + 1'b1) : lat_rad;
    az_mag  = az_rad[DW-1] ? (~az_rad + 1'b1) : az_rad;
  end

  // ---------------- divider and mod-2pi chain ----------------
  // Each step yields one quotient bit of (distance << 30) / radius and folds it
  // into the residue mod 2*pi; latitude and azimuth magnitudes reduce alongside.
  logic               md_vld_r    [0:DIV_BITS];
  logic [31:0]        md_dist_r   [0:31];
  logic [31:0]        md_rem_r    [0:DIV_BITS];
  logic [32:0]        md_dm_r     [0:DIV_BITS];
  logic [32:0]        md_lm_r     [0:DIV_BITS];
  logic [32:0]        md_am_r     [0:DIV_BITS];
  logic [DW-1:0]      md_latmag_r [0:DIV_BITS-1];
  logic [DW-1:0]      md_azmag_r  [0:DIV_BITS-1];
  logic               md_latneg_r [0:DIV_BITS];
  logic               md_azneg_r  [0:DIV_BITS];
  logic signed [24:0] md_lon_r    [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_vld_r[0] <= 1'b0;
    end else if (adv) begin
      md_vld_r[0]    <= s1_vld_r;
      md_dist_r[0]   <= s1_dist_r;
      md_rem_r[0]    <= '0;
      md_dm_r[0]     <= '0;
      md_lm_r[0]     <= '0;
      md_am_r[0]     <= '0;
      md_latmag_r[0] <= lat_mag;
      md_azmag_r[0]  <= az_mag;
      md_latneg_r[0] <= lat_rad[DW-1];
      md_azneg_r[0]  <= az_rad[DW-1];
      md_lon_r[0]    <= s1_lon_r;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_mod
    localparam int DB = DIV_BITS - 1 - k;
    logic        dbit, lbit, abit, qb;
    logic [32:0] rem2;

    if (k < 32) begin : g_dbit
      assign dbit = md_dist_r[k][31-k];
      if (k < 31) begin : g_dcarry
        always_ff @(posedge clk) begin
          if (adv) md_dist_r[k+1] <= md_dist_r[k];
        end
      end
    end else begin : g_dzero
      assign dbit = 1'b0;
    end

    if (DB < DW) begin : g_abit
      assign lbit = md_latmag_r[k][DB];
      assign abit = md_azmag_r[k][DB];
    end else begin : g_azero
      assign lbit = 1'b0;
      assign abit = 1'b0;
    end

    if (k < DIV_BITS - 1) begin : g_mcarry
      always_ff @(posedge clk) begin
        if (adv) begin
          md_latmag_r[k+1] <= md_latmag_r[k];
          md_azmag_r[k+1]  <= md_azmag_r[k];
        end
      end
    end

    assign rem2 = {md_rem_r[k], dbit};
    assign qb   = rem2 >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        md_vld_r[k+1]    <= md_vld_r[k];
        md_rem_r[k+1]    <= qb ? 32'(rem2 - {1'b0, divisor}) : rem2[31:0];
        md_dm_r[k+1]     <= mod_step(md_dm_r[k], qb);
        md_lm_r[k+1]     <= mod_step(md_lm_r[k], lbit);
        md_am_r[k+1]     <= mod_step(md_am_r[k], abit);
        md_latneg_r[k+1] <= md_latneg_r[k];
        md_azneg_r[k+1]  <= md_azneg_r[k];
        md_lon_r[k+1]    <= md_lon_r[k];
      end
    end
  end

  // ---------------- wrap and fold, rotation CORDIC ----------------
  // channel 0: latitude, 1: angular distance, 2: azimuth
  fold_t fold_lat, fold_dlt, fold_az;

  assign fold_lat = wrap_fold(md_lm_r[DIV_BITS], md_latneg_r[DIV_BITS]);
  assign fold_dlt = wrap_fold(md_dm_r[DIV_BITS], 1'b0);
  assign fold_az  = wrap_fold(md_am_r[DIV_BITS], md_azneg_r[DIV_BITS]);

  logic                 rv_r   [0:CS];
  logic signed [AW-1:0] rx_r   [0:CS][0:2];
  logic signed [AW-1:0] ry_r   [0:CS][0:2];
  logic signed [AW-1:0] rz_r   [0:CS][0:2];
  logic                 rn_r   [0:CS][0:2];
  logic signed [24:0]   rlon_r [0:CS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (adv) begin
      rv_r[0]    <= md_vld_r[DIV_BITS];
      rlon_r[0]  <= md_lon_r[DIV_BITS];
      rz_r[0][0] <= fold_lat.z;
      rz_r[0][1] <= fold_dlt.z;
      rz_r[0][2] <= fold_az.z;
      rn_r[0][0] <= fold_lat.neg;
      rn_r[0][1] <= fold_dlt.neg;
      rn_r[0][2] <= fold_az.neg;
      for (int j = 0; j < 3; j++) begin
        rx_r[0][j] <= GAIN_Q30;
        ry_r[0][j] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_rot
    localparam logic signed [AW-1:0] ATAN_I = atan_q30(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[i+1] <= 1'b0;
      end else if (adv) begin
        rv_r[i+1]   <= rv_r[i];
        rlon_r[i+1] <= rlon_r[i];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_ch
      logic signed [AW-1:0] dx, dy;
      assign dx = ry_r[i][j] >>> i;
      assign dy = rx_r[i][j] >>> i;

      always_ff @(posedge clk) begin
        if (adv) begin
          rn_r[i+1][j] <= rn_r[i][j];
          if (rz_r[i][j] >= 0) begin
            rx_r[i+1][j] <= rx_r[i][j] - dx;
            ry_r[i+1][j] <= ry_r[i][j] + dy;
            rz_r[i+1][j] <= rz_r[i][j] - ATAN_I;
          end else begin
            rx_r[i+1][j] <= rx_r[i][j] + dx;
            ry_r[i+1][j] <= ry_r[i][j] - dy;
            rz_r[i+1][j] <= rz_r[i][j] + ATAN_I;
          end
        end
      end
    end
  end

  // ---------------- P1..P3: spherical products ----------------
  logic signed [AW-1:0] sn [0:2];
  logic signed [AW-1:0] cs [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sn[j] = rn_r[CS][j] ? -ry_r[CS][j] : ry_r[CS][j];
      cs[j] = rn_r[CS][j] ? -rx_r[CS][j] : rx_r[CS][j];
    end
  end

  logic                 p1_vld_r, p2_vld_r, p3_vld_r;
  logic signed [AW-1:0] p1_slcd_r, p1_clsd_r, p1_slsd_r, p1_clcd_r, p1_num_r, p1_ca_r;
  logic signed [AW-1:0] p2_slcd_r, p2_clcd_r, p2_a_r, p2_b_r, p2_num_r;
  logic signed [24:0]   p1_lon_r, p2_lon_r, p3_lon_r;
  logic signed [AW:0]   s_sum;
  logic signed [31:0]   p3_s_r;
  logic signed [AW:0]   p3_den_r;
  logic signed [AW-1:0] p3_num_r;

  always_comb begin
    s_sum = (AW+1)'(p2_slcd_r) + (AW+1)'(p2_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r  <= rv_r[CS];
      p1_lon_r  <= rlon_r[CS];
      p1_slcd_r <= qmul(sn[0], cs[1]);
      p1_clsd_r <= qmul(cs[0], sn[1]);
      p1_slsd_r <= qmul(sn[0], sn[1]);
      p1_clcd_r <= qmul(cs[0], cs[1]);
      p1_num_r  <= qmul(sn[1], sn[2]);
      p1_ca_r   <= cs[2];

      p2_vld_r  <= p1_vld_r;
      p2_lon_r  <= p1_lon_r;
      p2_slcd_r <= p1_slcd_r;
      p2_clcd_r <= p1_clcd_r;
      p2_a_r    <= qmul(p1_clsd_r, p1_ca_r);
      p2_b_r    <= qmul(p1_slsd_r, p1_ca_r);
      p2_num_r  <= p1_num_r;

      p3_vld_r <= p2_vld_r;
      p3_lon_r <= p2_lon_r;
      // clamp the asin argument to one
      if (s_sum > Q30_ONE) begin
        p3_s_r <= 32'(Q30_ONE);
      end else if (s_sum < -Q30_ONE) begin
        p3_s_r <= 32'(-Q30_ONE);
      end else begin
        p3_s_r <= 32'(s_sum);
      end
      p3_den_r <= (AW+1)'(p2_clcd_r) - (AW+1)'(p2_b_r);
      p3_num_r <= p2_num_r;
    end
  end

  // ---------------- square root of 1 - s^2 ----------------
  logic [63:0] s_sq;
  assign s_sq = p3_s_r * p3_s_r;

  logic                 sq_vld_r [0:SQRT_STEPS];
  logic [60:0]          sq_v_r   [0:SQRT_STEPS];
  logic [61:0]          sq_res_r [0:SQRT_STEPS];
  logic signed [31:0]   sq_s_r   [0:SQRT_STEPS];
  logic signed [AW:0]   sq_den_r [0:SQRT_STEPS];
  logic signed [AW-1:0] sq_num_r [0:SQRT_STEPS];
  logic signed [24:0]   sq_lon_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= p3_vld_r;
      sq_v_r[0]   <= 61'((64'd1 << 60) - s_sq);
      sq_res_r[0] <= '0;
      sq_s_r[0]   <= p3_s_r;
      sq_den_r[0] <= p3_den_r;
      sq_num_r[0] <= p3_num_r;
      sq_lon_r[0] <= p3_lon_r;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [61:0] BIT_K = 62'd1 << (60 - 2 * k);
    logic [61:0] trial;
    logic        take;

    assign trial = sq_res_r[k] + BIT_K;
    assign take  = {1'b0, sq_v_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
        sq_v_r[k+1]   <= take ? 61'({1'b0, sq_v_r[k]} - trial) : sq_v_r[k];
        sq_res_r[k+1] <= take ? (sq_res_r[k] >> 1) + BIT_K : sq_res_r[k] >> 1;
        sq_s_r[k+1]   <= sq_s_r[k];
        sq_den_r[k+1] <= sq_den_r[k];
        sq_num_r[k+1] <= sq_num_r[k];
        sq_lon_r[k+1] <= sq_lon_r[k];
      end
    end
  end

  // ---------------- vectoring CORDIC: atan2 ----------------
  // channel 0: latitude atan2(s, sqrt(1 - s^2)), 1: longitude offset
  logic signed [VW-1:0] vx_in [0:1];
  logic signed [VW-1:0] vy_in [0:1];

  assign vx_in[0] = VW'(sq_res_r[SQRT_STEPS][30:0]);
  assign vy_in[0] = VW'(sq_s_r[SQRT_STEPS]);
  assign vx_in[1] = VW'(sq_den_r[SQRT_STEPS]);
  assign vy_in[1] = VW'(sq_num_r[SQRT_STEPS]);

  logic                 vv_r   [0:CS];
  logic signed [VW-1:0] vx_r   [0:CS][0:1];
  logic signed [VW-1:0] vy_r   [0:CS][0:1];
  logic signed [AW-1:0] vz_r   [0:CS][0:1];
  logic                 vzr_r  [0:CS][0:1];
  logic signed [24:0]   vlon_r [0:CS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r[0] <= 1'b0;
    end else if (adv) begin
      vv_r[0]   <= sq_vld_r[SQRT_STEPS];
      vlon_r[0] <= sq_lon_r[SQRT_STEPS];
      for (int j = 0; j < 2; j++) begin
        vzr_r[0][j] <= (vx_in[j] == '0) && (vy_in[j] == '0);
        // negative abscissa: turn by a half turn first
        if (vx_in[j] < 0) begin
          vx_r[0][j] <= -vx_in[j];
          vy_r[0][j] <= -vy_in[j];
          vz_r[0][j] <= (vy_in[j] >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
          vx_r[0][j] <= vx_in[j];
          vy_r[0][j] <= vy_in[j];
          vz_r[0][j] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_vec
    localparam logic signed [AW-1:0] ATAN_I = atan_q30(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[i+1] <= 1'b0;
      end else if (adv) begin
        vv_r[i+1]   <= vv_r[i];
        vlon_r[i+1] <= vlon_r[i];
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_ch
      logic signed [VW-1:0] dx, dy;
      assign dx = vy_r[i][j] >>> i;
      assign dy = vx_r[i][j] >>> i;

      always_ff @(posedge clk) begin
        if (adv) begin
          vzr_r[i+1][j] <= vzr_r[i][j];
          if (vy_r[i][j] >= 0) begin
            vx_r[i+1][j] <= vx_r[i][j] + dx;
            vy_r[i+1][j] <= vy_r[i][j] - dy;
            vz_r[i+1][j] <= vz_r[i][j] + ATAN_I;
          end else begin
            vx_r[i+1][j] <= vx_r[i][j] - dx;
            vy_r[i+1][j] <= vy_r[i][j] + dy;
            vz_r[i+1][j] <= vz_r[i][j] - ATAN_I;
          end
        end
      end
    end
  end

  // ---------------- R1: radians to degrees, R2: round and output ----------------
  logic               r1_vld_r;
  logic signed [MW-1:0] r1_m_r [0:1];
  logic signed [24:0] r1_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
    end else if (adv) begin
      r1_vld_r <= vv_r[CS];
      r1_lon_r <= vlon_r[CS];
      for (int j = 0; j < 2; j++) begin
        r1_m_r[j] <= (vzr_r[CS][j] ? Z_ORIGIN : vz_r[CS][j]) * RAD2DEG_S;
      end
    end
  end

  logic signed [MW-1:0] lat_deg, lon_deg;

  always_comb begin
    lat_deg = (r1_m_r[0] + (MW'(1) <<< (RSH - 1))) >>> RSH;
    lon_deg = (r1_m_r[1] + (MW'(1) <<< (RSH - 1))) >>> RSH;
  end

  logic               out_valid_r;
  logic signed [23:0] dest_lat_r;
  logic signed [25:0] dest_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= r1_vld_r;
      dest_lat_r  <= lat_deg[23:0];
      dest_lon_r  <= 26'(r1_lon_r) + lon_deg[25:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dest_lat = dest_lat_r;
  assign out_dest_lon = dest_lon_r;

endmodule

// ===== rtl/core/gcdp_chk.sv =====
// Port-level checker for great_circle_destination_point, attached by bind.
// Depends only on the top level's ports.
module gcdp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] out_dest_lat,
  input logic signed [25:0] out_dest_lon
);

  // a result held back by a stall stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped during a stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_dest_lat) && $stable(out_dest_lon))
    else $error("result changed during a stall");

  // input back-pressure only ever comes from a stalled, waiting result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // reset drains the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind great_circle_destination_point gcdp_chk u_gcdp_chk (.*);

// ===== tb/great_circle_destination_point_tb.sv =====
// Self-checking testbench for great_circle_destination_point.
// Holds its own fixed-point model of the destination formulas and checks each output transfer.
// Depends on gcdp_pkg and the great_circle_destination_point RTL.
module great_circle_destination_point_tb;
  import gcdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  PIPE_LAT   = 152;
  localparam int  IDLE_LIMIT = 5000;
  localparam int  ITEMS_PER_PHASE = 200;
  localparam longint DEG_TO_RAD = 64'sd19190098069;
  localparam longint RAD_TO_DEG = 64'sd961263669;

  typedef struct {
    logic signed [23:0] lat;
    logic signed [24:0] lon;
    logic signed [25:0] az;
    logic [31:0]        trav_dist;
  } query_t;

  typedef struct {
    logic signed [23:0] lat;
    logic signed [25:0] lon;
  } dest_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [23:0] in_start_lat;
  logic signed [24:0] in_start_lon;
  logic signed [25:0] in_azimuth;
  logic [31:0]        in_travel_distance;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] out_dest_lat;
  logic signed [25:0] out_dest_lon;
  logic               cfg_wr_en;
  logic [31:0]        cfg_wr_data;

  logic [31:0] radius;
  dest_t       dest_q[$];
  bit          failed = 1'b0;
  int          stall_pct;
  int          gap_max;
  int          idle_cycles = 0;

  great_circle_destination_point u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_lat      (in_start_lat),
    .in_start_lon      (in_start_lon),
    .in_azimuth        (in_azimuth),
    .in_travel_distance(in_travel_distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_dest_lat      (out_dest_lat),
    .out_dest_lon      (out_dest_lon),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------- fixed-point destination model ----------------

  const longint arctan_q30[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint reduce_angle(longint v);
    longint m;
    m = v % longint'(TWO_PI_Q30);
    if (m < 0) m += longint'(TWO_PI_Q30);
    if (m > longint'(PI_Q30)) m -= longint'(TWO_PI_Q30);
    return m;
  endfunction

  function automatic void rot_sincos(longint a, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 0;
    z = reduce_angle(a);
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30[i];
      end else begin
        x += dx; y -= dy; z += arctan_q30[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: turn by a half turn first
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q30[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q30[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic dest_t destination(query_t q, logic [31:0] rad_reg);
    longint lat, az, delta, sl, cl, sd, cd, sa, ca, s, t, den, num, latd, lond;
    longint unsigned rad, quo, rem;
    dest_t d;
    lat = round_shr(longint'(q.lat) * DEG_TO_RAD, 26);
    az  = round_shr(longint'(q.az) * DEG_TO_RAD, 26);
    rad = (rad_reg == 0) ? 64'd1 : 64'(rad_reg);
    quo = 64'(q.trav_dist) / rad;
    rem = 64'(q.trav_dist) % rad;
    delta = reduce_angle(longint'((quo << 30) + ((rem << 30) / rad)));
    rot_sincos(lat, sl, cl);
    rot_sincos(delta, sd, cd);
    rot_sincos(az, sa, ca);
    s = q30_mul(sl, cd) + q30_mul(q30_mul(cl, sd), ca);
    if (s > longint'(Q30_ONE)) s = longint'(Q30_ONE);
    if (s < -longint'(Q30_ONE)) s = -longint'(Q30_ONE);
    t = longint'(int_sqrt((64'd1 << 60) - longint'(s * s)));
    latd = round_shr(vec_atan2(s, t) * RAD_TO_DEG, 38);
    den = q30_mul(cl, cd) - q30_mul(q30_mul(sl, sd), ca);
    num = q30_mul(sd, sa);
    lond = longint'(q.lon) + round_shr(vec_atan2(num, den) * RAD_TO_DEG, 38);
    d.lat = latd[23:0];
    d.lon = lond[25:0];
    return d;
  endfunction

  // ---------------- output side ----------------

  always @(posedge clk) begin
    dest_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (dest_q.size() == 0) begin
          $error("output transfer with no destination pending");
          failed = 1;
        end else begin
          e = dest_q.pop_front();
          if (out_dest_lat !== e.lat) begin
            $error("dest_lat: expected %0d, got %0d", e.lat, out_dest_lat);
            failed = 1;
          end
          if (out_dest_lon !== e.lon) begin
            $error("dest_lon: expected %0d, got %0d", e.lon, out_dest_lon);
            failed = 1;
          end
        end
      end
    end
  end

  // count cycles with work pending and no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && dest_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("great_circle_destination_point_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------- input side ----------------

  int burst_left;

  task automatic send_query(query_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_start_lat       <= q.lat;
    in_start_lon       <= q.lon;
    in_azimuth         <= q.az;
    in_travel_distance <= q.trav_dist;
    dest_q.push_back(destination(q, radius));
    do @(posedge clk); while (in_stall);
  endtask

  // hold until drained, then let the pipe empty before touching the radius
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dest_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_radius(logic [31:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius = value;
  endtask

  function automatic query_t random_query();
    query_t q;
    if ($urandom_range(0, 4) != 0) begin
      q.lat = 24'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
      q.lon = 25'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
      q.az  = 26'(int'($urandom_range(0, 2 * 23592960)) - 23592960);
    end else begin
      q.lat = 24'($urandom);
      q.lon = 25'($urandom);
      q.az  = 26'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       q.trav_dist = $urandom;
      1:       q.trav_dist = $urandom_range(0, 1000);
      default: q.trav_dist = $urandom_range(0, 40000000);
    endcase
    return q;
  endfunction

  query_t directed[] = '{
    '{24'sd0,        25'sd0,         26'sd0,         32'd0},
    '{24'sd5898240,  25'sd0,         26'sd0,         32'd1000},
    '{-24'sd5898240, 25'sd0,         26'sd11796480,  32'd1000},
    '{24'sd5898240,  25'sd11796480,  26'sd0,         32'd0},
    '{24'sd0,        25'sd11796480,  26'sd5898240,   32'd20015087},
    '{24'sd0,        -25'sd11796480, -26'sd5898240,  32'd20015087},
    '{24'sd3276800,  25'sd11796480,  26'sd23592960,  32'd10007543},
    '{-24'sd3276800, -25'sd11796480, -26'sd23592960, 32'd40030174},
    '{24'sh7FFFFF,   25'sh0FFFFFF,   26'sh1FFFFFF,   32'hFFFFFFFF},
    '{24'sh800000,   25'sh1000000,   26'sh2000000,   32'hFFFFFFFF},
    '{24'sd5898239,  25'sd100,       26'sd11796480,  32'd20015086},
    '{24'sd0,        25'sd0,         26'sd11796480,  32'd20015087},
    '{24'sd655360,   -25'sd655360,   26'sd2949120,   32'd6371000},
    '{24'sd0,        25'sd0,         26'sd5898240,   32'd1},
    '{24'sh555555,   25'sh0AAAAAA,   26'sh1555555,   32'h55555555},
    '{24'shAAAAAA,   25'sh1555555,   26'sh2AAAAAA,   32'hAAAAAAAA}
  };

  logic [31:0] radius_plan[7];
  int          stall_plan[7] = '{0, 30, 60, 10, 0, 45, 20};
  int          gap_plan[7]   = '{0, 4, 0, 8, 2, 6, 3};

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_start_lat       <= '0;
    in_start_lon       <= '0;
    in_azimuth         <= '0;
    in_travel_distance <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    stall_pct   = 0;
    gap_max     = 0;
    burst_left  = 0;
    radius      = RADIUS_RESET;
    radius_plan = '{32'd6371000, 32'd1, 32'd0, 32'hFFFFFFFF,
                    $urandom_range(100, 10000000), $urandom, 32'd6371000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radius, then spot values
    stall_pct = 20;
    gap_max   = 3;
    foreach (directed[i]) send_query(directed[i]);

    for (int p = 0; p < 7; p++) begin
      write_radius(radius_plan[p]);
      stall_pct = stall_plan[p];
      gap_max   = gap_plan[p];
      if (p == 2) foreach (directed[i]) send_query(directed[i]);
      repeat (ITEMS_PER_PHASE) send_query(random_query());
    end

    in_valid <= 1'b0;
    while (dest_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (!failed)
      $display("great_circle_destination_point_tb OK");
    else
      $display("great_circle_destination_point_tb NOT OK");
    $finish;
  end

endmodule
